### rtl/vlpp_pkg.sv
// ----------------------------------------------------------------------------
// vlpp_pkg
// Types, constants and codes shared by the video line packet planner.
// ----------------------------------------------------------------------------
`default_nettype none

package vlpp_pkg;

	localparam int MAX_SRD_DEF = 4;
	localparam int PIXELS_PER_PGROUP_DEF = 2;
	localparam int CMD_DEPTH = 2;

	localparam int DIV_W = 16;
	localparam int PG_W = 7;

	localparam int RTP_HDR_OCTETS = 12;
	localparam int EXT_SEQ_OCTETS = 2;
	localparam int SRD_HDR_OCTETS = 6;
	localparam int FIXED_HDR_OCTETS = RTP_HDR_OCTETS + EXT_SEQ_OCTETS;

	localparam logic KIND_START = 1'b0;

	localparam logic [14:0] FRAME_HEIGHT_RST = 15'd1080;
	localparam logic [15:0] LINE_OCTETS_RST = 16'd4800;
	localparam logic [6:0] PGROUP_OCTETS_RST = 7'd5;
	localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd1428;

	typedef enum logic [1:0] {
		CFG_FRAME_HEIGHT,
		CFG_LINE_OCTETS,
		CFG_PGROUP_OCTETS,
		CFG_PAYLOAD_LIMIT
	} cfg_idx_t;

	typedef struct packed {
		logic [14:0] frame_height;
		logic [15:0] line_octets;
		logic [6:0] pgroup_octets;
		logic [15:0] payload_limit;
	} cfg_t;

	typedef struct packed {
		logic kind;
		logic [31:0] frame_timestamp;
	} item_t;

	typedef struct packed {
		logic packet_valid;
		logic [15:0] segment_length;
		logic [14:0] segment_line;
		logic [14:0] segment_pixel_offset;
		logic [31:0] sequence_number;
		logic [31:0] packet_timestamp;
		logic frame_end_marker;
		logic [15:0] payload_length;
		logic last;
	} result_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [PG_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_LEN,
		ST_MUL_LEN,
		ST_TEST_LEN,
		ST_DIV_OFF,
		ST_STORE,
		ST_FINISH,
		ST_EMIT,
		ST_EMIT_INV
	} plan_state_t;

endpackage

`default_nettype wire

### rtl/vlpp_cmd_queue.sv
// ----------------------------------------------------------------------------
// vlpp_cmd_queue
// Front end: accepts input beats into a short queue for the planner.
// ----------------------------------------------------------------------------
`default_nettype none

module vlpp_cmd_queue import vlpp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire item_t item,
	input wire logic push,
	output logic full,
	output item_t head,
	output logic empty,
	input wire logic pop
);
	localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CW = $clog2(CMD_DEPTH + 1);

	item_t slot_q [CMD_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CW'(CMD_DEPTH));
	assign empty = (count_q == '0);
	assign head = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

endmodule

`default_nettype wire

### rtl/vlpp_divider.sv
// ----------------------------------------------------------------------------
// vlpp_divider
// Restoring divider, one quotient bit per cycle, for pixel group alignment.
// ----------------------------------------------------------------------------
`default_nettype none

module vlpp_divider import vlpp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output div_rsp_t rsp
);
	localparam int CNT_W = $clog2(DIV_W);

	logic busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PG_W-1:0] rem_q, divisor_q;
	logic [DIV_W-1:0] quo_q;
	logic [PG_W:0] rem_sh;
	logic take;

	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign take = (rem_sh >= {1'b0, divisor_q});

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? PG_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[PG_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

endmodule

`default_nettype wire

### rtl/vlpp_planner.sv
// ----------------------------------------------------------------------------
// vlpp_planner
// Back end: walks the frame cursor, plans segments and emits result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module vlpp_planner import vlpp_pkg::*; #(
	parameter int MaxSrd = MAX_SRD_DEF,
	parameter int PixelsPerPgroup = PIXELS_PER_PGROUP_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire item_t cmd,
	input wire logic cmd_empty,
	output logic cmd_pop,
	output div_req_t div_req,
	input wire div_rsp_t div_rsp,
	output result_t result,
	output logic empty,
	input wire logic pop
);
	localparam int NW = $clog2(MaxSrd + 1);
	localparam int IW = (MaxSrd > 1) ? $clog2(MaxSrd) : 1;
	localparam int OW = DIV_W + $clog2(PixelsPerPgroup + 1);
	localparam int LW = DIV_W + PG_W;

	plan_state_t state_q, state_d;

	logic [15:0] line_q, octet_q, seg_q;
	logic signed [17:0] budget_q;
	logic [NW-1:0] n_q;
	logic [16:0] data_q;
	logic [IW-1:0] k_q;
	logic [14:0] line_cursor_q;
	logic [15:0] octet_cursor_q;
	logic [31:0] ts_q, seq_q;
	logic active_q, marker_q;
	logic [15:0] plen_q;
	logic [15:0] seg_len_q [MaxSrd];
	logic [14:0] seg_line_q [MaxSrd];
	logic [14:0] seg_off_q [MaxSrd];
	logic out_valid_q;
	result_t out_q;

	logic [PG_W-1:0] pg;
	logic signed [17:0] spare_octets;
	logic [15:0] left, room;
	logic can_seg, k_last, out_free, out_load;
	logic [16:0] oct_sum;
	logic [OW-1:0] off_prod;
	logic [LW-1:0] len_prod;
	result_t out_d;

	assign pg = (cfg.pgroup_octets == '0) ? PG_W'(1) : cfg.pgroup_octets;
	assign spare_octets = budget_q - 18'sd6;
	assign left = (octet_q < cfg.line_octets) ? cfg.line_octets - octet_q : 16'd0;
	assign room = (left < spare_octets[15:0]) ? left : spare_octets[15:0];
	assign can_seg = (line_q < {1'b0, cfg.frame_height}) && (n_q < NW'(MaxSrd))
		&& (spare_octets >= $signed({11'd0, pg}));
	assign k_last = ({{(NW > IW ? NW - IW : 1){1'b0}}, k_q} == NW'(n_q - 1'b1));
	assign oct_sum = {1'b0, octet_q} + {1'b0, seg_q};
	assign off_prod = OW'(div_rsp.quotient) * OW'(PixelsPerPgroup);
	assign len_prod = LW'(div_rsp.quotient) * LW'(pg);
	assign out_free = !out_valid_q || pop;

	assign empty = !out_valid_q;
	assign result = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty && cmd.kind != KIND_START) begin
					state_d = active_q ? ST_CHECK : ST_EMIT_INV;
				end
			end
			ST_CHECK: state_d = can_seg ? ST_DIV_LEN : ST_FINISH;
			ST_DIV_LEN: if (div_rsp.done) begin
				state_d = ST_MUL_LEN;
			end
			ST_MUL_LEN: state_d = ST_TEST_LEN;
			ST_TEST_LEN: state_d = (seg_q == '0) ? ST_FINISH : ST_DIV_OFF;
			ST_DIV_OFF: if (div_rsp.done) begin
				state_d = ST_STORE;
			end
			ST_STORE: state_d = ST_CHECK;
			ST_FINISH: state_d = (n_q == '0) ? ST_EMIT_INV : ST_EMIT;
			ST_EMIT: if (out_free && k_last) begin
				state_d = ST_IDLE;
			end
			ST_EMIT_INV: if (out_free) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd_pop = 1'b0;
		div_req.start = 1'b0;
		div_req.dividend = octet_q;
		div_req.divisor = pg;
		out_load = 1'b0;
		out_d = '0;
		out_d.last = 1'b1;
		case (state_q)
			ST_IDLE: cmd_pop = !cmd_empty;
			ST_CHECK: begin
				div_req.start = can_seg;
				div_req.dividend = room;
			end
			ST_TEST_LEN: div_req.start = (seg_q != '0);
			ST_EMIT: begin
				out_load = out_free;
				out_d.packet_valid = 1'b1;
				out_d.segment_length = seg_len_q[k_q];
				out_d.segment_line = seg_line_q[k_q];
				out_d.segment_pixel_offset = seg_off_q[k_q];
				out_d.sequence_number = seq_q;
				out_d.packet_timestamp = ts_q;
				out_d.frame_end_marker = marker_q;
				out_d.payload_length = plen_q;
				out_d.last = k_last;
			end
			ST_EMIT_INV: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_cursor_q <= '0;
			octet_cursor_q <= '0;
			ts_q <= '0;
			active_q <= 1'b0;
			seq_q <= '0;
			out_valid_q <= 1'b0;
			n_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					n_q <= '0;
					k_q <= '0;
					if (!cmd_empty && cmd.kind == KIND_START) begin
						line_cursor_q <= '0;
						octet_cursor_q <= '0;
						ts_q <= cmd.frame_timestamp;
						active_q <= 1'b1;
					end
				end
				ST_STORE: n_q <= n_q + 1'b1;
				ST_FINISH: begin
					if (n_q == '0) begin
						active_q <= 1'b0;
					end else begin
						line_cursor_q <= line_q[14:0];
						octet_cursor_q <= octet_q;
						if (line_q >= {1'b0, cfg.frame_height}) begin
							active_q <= 1'b0;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						k_q <= k_q + 1'b1;
						if (k_last) begin
							seq_q <= seq_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
		case (state_q)
			ST_IDLE: begin
				line_q <= {1'b0, line_cursor_q};
				octet_q <= octet_cursor_q;
				budget_q <= $signed({2'b00, cfg.payload_limit}) - 18'(FIXED_HDR_OCTETS);
				data_q <= '0;
			end
			ST_MUL_LEN: seg_q <= len_prod[15:0];
			ST_STORE: begin
				seg_len_q[n_q[IW-1:0]] <= seg_q;
				seg_line_q[n_q[IW-1:0]] <= line_q[14:0];
				seg_off_q[n_q[IW-1:0]] <= off_prod[14:0];
				data_q <= data_q + {1'b0, seg_q};
				budget_q <= budget_q - 18'(SRD_HDR_OCTETS) - $signed({2'b00, seg_q});
				if (oct_sum >= {1'b0, cfg.line_octets}) begin
					octet_q <= '0;
					line_q <= line_q + 1'b1;
				end else begin
					octet_q <= oct_sum[15:0];
				end
			end
			ST_FINISH: begin
				marker_q <= (line_q >= {1'b0, cfg.frame_height});
				plen_q <= 16'(17'(FIXED_HDR_OCTETS) + 17'(n_q) * 17'(SRD_HDR_OCTETS) + data_q);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### rtl/video_line_packet_planner.sv
// ----------------------------------------------------------------------------
// video_line_packet_planner
// Plans uncompressed-video packets: segments of pixel rows per request beat.
// Start beat: leaves the input queue when the idle planner pops it, gives no result.
// Request beat: each segment is planned with two divides (length, then offset)
// on the one-bit-per-cycle divider, then one result beat per cycle unless the receiver stalls.
// Input queue holds 2 beats while the planner works.
// Reset clears the cursor, sequence, queues and loads default registers.
// ----------------------------------------------------------------------------
`default_nettype none

module video_line_packet_planner import vlpp_pkg::*; #(
	parameter int MaxSrd = MAX_SRD_DEF,
	parameter int PixelsPerPgroup = PIXELS_PER_PGROUP_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire item_t item,
	input wire logic push,
	output logic full,
	output result_t result,
	output logic empty,
	input wire logic pop,
	input wire logic cfg_wr_en,
	input wire logic [1:0] cfg_addr,
	input wire logic [15:0] cfg_wdata
);
	cfg_t cfg_q;
	item_t head;
	logic head_empty, head_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
			cfg_q.line_octets <= LINE_OCTETS_RST;
			cfg_q.pgroup_octets <= PGROUP_OCTETS_RST;
			cfg_q.payload_limit <= PAYLOAD_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_wdata[14:0];
				CFG_LINE_OCTETS: cfg_q.line_octets <= cfg_wdata;
				CFG_PGROUP_OCTETS: cfg_q.pgroup_octets <= cfg_wdata[6:0];
				CFG_PAYLOAD_LIMIT: cfg_q.payload_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

	vlpp_cmd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.push(push),
		.full(full),
		.head(head),
		.empty(head_empty),
		.pop(head_pop)
	);

	vlpp_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	vlpp_planner #(
		.MaxSrd(MaxSrd),
		.PixelsPerPgroup(PixelsPerPgroup)
	) u_plan (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(head),
		.cmd_empty(head_empty),
		.cmd_pop(head_pop),
		.div_req(div_req),
		.div_rsp(div_rsp),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

endmodule

`default_nettype wire

### rtl/vlpp_checker.sv
// ----------------------------------------------------------------------------
// vlpp_checker
// Port-level checks on the planner's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module vlpp_checker import vlpp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire result_t result,
	input wire logic empty,
	input wire logic pop
);
	// hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("stalled result beat changed");

	// an invalid beat stands alone and carries nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.packet_valid |-> result.last && result.segment_length == 16'd0
			&& result.payload_length == 16'd0 && !result.frame_end_marker)
		else $error("invalid result beat malformed");

	// payload covers headers and this segment
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.packet_valid |->
			{1'b0, result.payload_length} >= {1'b0, result.segment_length} + 17'd20
			&& result.segment_length != 16'd0)
		else $error("payload length below segment length");

endmodule

bind video_line_packet_planner vlpp_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.result(result),
	.empty(empty),
	.pop(pop)
);

`default_nettype wire

### bench/packet_plan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_plan_checker
// Watches the item and result queues of the packet planner, predicts the
// segment results of every accepted item and compares them in order.
// ----------------------------------------------------------------------------

module packet_plan_checker import vlpp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire item_t item,
	input wire logic push,
	input wire logic full,
	input wire result_t result,
	input wire logic empty,
	input wire logic pop,
	input wire logic cfg_wr_en,
	input wire logic [1:0] cfg_addr,
	input wire logic [15:0] cfg_wdata,
	output int errors,
	output int pending
);

	localparam int MaxSegments = MAX_SRD_DEF;
	localparam int PixelsPerGroup = PIXELS_PER_PGROUP_DEF;

	logic [14:0] frame_height;
	logic [15:0] line_octets;
	logic [6:0] pgroup_octets;
	logic [15:0] payload_limit;
	logic [14:0] line_pos;
	logic [15:0] octet_pos;
	logic [31:0] frame_ts;
	logic armed;
	logic [31:0] seq_next;
	result_t planned_q[$];

	assign pending = planned_q.size();

	function automatic result_t blank_result();
		result_t r;
		r = '0;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic plan_packet(input item_t it);
		int unsigned pg, line, octet, data, left, seg, n;
		int budget, room;
		result_t segs[MaxSegments];
		logic marker;
		if (it.kind == KIND_START) begin
			line_pos = '0;
			octet_pos = '0;
			frame_ts = it.frame_timestamp;
			armed = 1'b1;
			return;
		end
		if (!armed) begin
			planned_q.push_back(blank_result());
			return;
		end
		pg = (pgroup_octets != 0) ? pgroup_octets : 1;
		line = line_pos;
		octet = octet_pos;
		budget = int'(payload_limit) - FIXED_HDR_OCTETS;
		data = 0;
		n = 0;
		while (line < frame_height && n < MaxSegments) begin
			room = budget - SRD_HDR_OCTETS;
			if (room < int'(pg))
				break;
			left = (octet < line_octets) ? line_octets - octet : 0;
			seg = (left < room) ? left : room;
			seg = (seg / pg) * pg;
			if (seg == 0)
				break;
			segs[n] = '0;
			segs[n].segment_length = seg[15:0];
			segs[n].segment_line = line[14:0];
			segs[n].segment_pixel_offset = 15'((octet / pg) * PixelsPerGroup);
			n++;
			data += seg;
			budget -= SRD_HDR_OCTETS + seg;
			octet += seg;
			if (octet >= line_octets) begin
				octet = 0;
				line++;
			end
		end
		if (n == 0) begin
			armed = 1'b0;
			planned_q.push_back(blank_result());
			return;
		end
		line_pos = line[14:0];
		octet_pos = octet[15:0];
		marker = line >= frame_height;
		if (marker)
			armed = 1'b0;
		for (int k = 0; k < n; k++) begin
			segs[k].packet_valid = 1'b1;
			segs[k].sequence_number = seq_next;
			segs[k].packet_timestamp = frame_ts;
			segs[k].frame_end_marker = marker;
			segs[k].payload_length = 16'(FIXED_HDR_OCTETS + SRD_HDR_OCTETS * n + data);
			segs[k].last = (k == n - 1);
			planned_q.push_back(segs[k]);
		end
		seq_next++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			frame_height <= FRAME_HEIGHT_RST;
			line_octets <= LINE_OCTETS_RST;
			pgroup_octets <= PGROUP_OCTETS_RST;
			payload_limit <= PAYLOAD_LIMIT_RST;
			line_pos = '0;
			octet_pos = '0;
			frame_ts = '0;
			armed = 1'b0;
			seq_next = '0;
			planned_q.delete();
			errors <= 0;
		end else begin
			if (pop && !empty) begin
				if (planned_q.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, result);
					errors <= errors + 1;
				end else begin
					want = planned_q.pop_front();
					if (want !== result) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, result);
						errors <= errors + 1;
					end
				end
			end
			// registers must only be written while idle (the user's duty, unchecked by the block), so order vs. items is moot
			if (push && !full)
				plan_packet(item);
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_addr))
					CFG_FRAME_HEIGHT: frame_height <= cfg_wdata[14:0];
					CFG_LINE_OCTETS: line_octets <= cfg_wdata;
					CFG_PGROUP_OCTETS: pgroup_octets <= cfg_wdata[6:0];
					CFG_PAYLOAD_LIMIT: payload_limit <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives frame starts and packet requests through several register settings
// and idling mixes; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------

module testbench;
	import vlpp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	item_t item = '0;
	logic push = 1'b0;
	logic full;
	result_t result;
	logic empty;
	logic pop = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;
	int errors;
	int pending;
	int send_idle = 0;
	int take_stall = 0;
	int hold_off = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	video_line_packet_planner DUT (
		.clk, .arst_n, .item, .push, .full, .result, .empty, .pop,
		.cfg_wr_en, .cfg_addr, .cfg_wdata
	);

	packet_plan_checker checker_i (
		.clk, .arst_n, .item, .push, .full, .result, .empty, .pop,
		.cfg_wr_en, .cfg_addr, .cfg_wdata, .errors, .pending
	);

	// receiver: random stall, plus a long hold-off counted here
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			pop <= 1'b0;
		end else
			pop <= ($urandom_range(99) >= take_stall);
	end

	// push stays high after the accepting edge; an idle draw in the next beat or a drain lowers it
	task automatic send_beat(input logic kind, input logic [31:0] ts);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		item <= '{kind: kind, frame_timestamp: ts};
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	task automatic drain_then_write(input cfg_idx_t idx, input logic [15:0] val);
		push <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_regs(input logic [15:0] h, input logic [15:0] lo,
			input logic [15:0] pg, input logic [15:0] lim);
		drain_then_write(CFG_FRAME_HEIGHT, h);
		drain_then_write(CFG_LINE_OCTETS, lo);
		drain_then_write(CFG_PGROUP_OCTETS, pg);
		drain_then_write(CFG_PAYLOAD_LIMIT, lim);
	endtask

	// mostly small frames: a start then 2 to 10 requests, else a lone random beat
	task automatic random_frames(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0) begin
				send_beat(1'($urandom_range(1)), $urandom());
				sent++;
			end else begin
				send_beat(KIND_START, $urandom());
				sent++;
				repeat ($urandom_range(2, 10)) begin
					send_beat(1'b1, $urandom());
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: request while idle, default registers, short frame
		send_beat(1'b1, 32'h0);
		send_beat(KIND_START, 32'hFFFF_FFFF);
		repeat (3) send_beat(1'b1, 32'h0);
		set_regs(16'd2, 16'd30, 16'd3, 16'd60);
		send_beat(KIND_START, 32'h8000_0001);
		repeat (6) send_beat(1'b1, 32'hFFFF_FFFF);
		// group size zero, budget below headers, tiny limit
		set_regs(16'd1, 16'd7, 16'd0, 16'd20);
		send_beat(KIND_START, 32'h1234_5678);
		repeat (3) send_beat(1'b1, 32'h0);
		set_regs(16'd32767, 16'd65535, 16'd64, 16'd65535);
		send_beat(KIND_START, 32'h0);
		repeat (3) send_beat(1'b1, 32'h0);
		// cursor left past a shortened line
		set_regs(16'd32767, 16'd10, 16'd5, 16'd65535);
		repeat (2) send_beat(1'b1, 32'h0);
		set_regs(16'd4, 16'd12, 16'd127, 16'd40);
		send_beat(KIND_START, 32'h5555_AAAA);
		repeat (2) send_beat(1'b1, 32'h0);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle = 0; take_stall = 0; end
				1: begin send_idle = 83; take_stall = 0; end
				2: begin send_idle = 0; take_stall = 83; end
				default: begin send_idle = 19; take_stall = 19; end
			endcase
			set_regs(16'($urandom_range(1, 6)), 16'(2 * $urandom_range(1, 40)),
				16'($urandom_range(1, 4) * 2 - (phase % 2)),
				16'($urandom_range(20, 120)));
			if (phase == 2)
				hold_off <= 400;
			random_frames(55);
		end
		push <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("PASS video_line_packet_planner");
		else
			$display("FAIL video_line_packet_planner");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL video_line_packet_planner");
		$finish;
	end

endmodule

### video_line_packet_planner.f
rtl/vlpp_pkg.sv
rtl/vlpp_cmd_queue.sv
rtl/vlpp_divider.sv
rtl/vlpp_planner.sv
rtl/video_line_packet_planner.sv
rtl/vlpp_checker.sv
bench/packet_plan_checker.sv
bench/testbench.sv
